// ----- rtl/phx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_pkg
// shared types and constants of the philox uniform stream generator
// ----------------------------------------------------------------------------
package phx_pkg;

    localparam logic [31:0] MUL_A  = 32'hD2511F53;
    localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
    localparam logic [31:0] WEYL_A = 32'h9E3779B9;
    localparam logic [31:0] WEYL_B = 32'hBB67AE85;

    localparam logic [63:0] HISTORY_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]  POS_EMPTY     = 3'd4;

    localparam logic OP_SET_HISTORY = 1'b0;
    localparam logic OP_DRAW        = 1'b1;

    localparam logic CFG_KEY_LO = 1'b0;
    localparam logic CFG_KEY_HI = 1'b1;

    typedef struct packed {
        logic load;
        logic mul;
        logic mix;
        logic bump;
        logic emit;
        logic set_hist;
    } phx_cmd_t;

    typedef struct packed {
        logic buf_empty;
        logic out_free;
    } phx_sts_t;

endpackage

// ----- rtl/phx_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_ctrl
// sequencer: accepts items, steps the shared round unit, issues emits
// ----------------------------------------------------------------------------
module phx_ctrl
    import phx_pkg::*;
#(
    parameter int ROUNDS = 10
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     op,
    input  phx_sts_t sts,
    output phx_cmd_t cmd
);

    localparam int RCNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [RCNT_W-1:0] rnd_reg;
    logic [RCNT_W-1:0] rnd_next;
    logic              accept;
    logic              last_round;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign last_round = (rnd_reg == RCNT_W'(ROUNDS - 1));

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_SET_HISTORY)
                    begin
                        cmd.set_hist = 1'b1;
                    end
                    else if (sts.buf_empty)
                    begin
                        cmd.load   = 1'b1;
                        rnd_next   = '0;
                        state_next = S_MUL;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                if (last_round)
                begin
                    cmd.bump   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

// ----- rtl/phx_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_datapath
// counter, key and buffer registers, shared philox round unit, output stage
// ----------------------------------------------------------------------------
module phx_datapath
    import phx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [63:0] history,
    input  phx_cmd_t    cmd,
    output phx_sts_t    sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [32:0] uniform_value
);

    logic [31:0] key_lo_reg;
    logic [31:0] key_hi_reg;
    logic [63:0] draw_cnt_reg;
    logic [63:0] hist_reg;
    logic [2:0]  pos_reg;
    logic        out_valid_reg;
    logic [32:0] out_value_reg;

    // working words double as the four-word buffer after the last round
    logic [31:0] c_reg [4];
    logic [31:0] k0_reg;
    logic [31:0] k1_reg;
    logic [63:0] pa_reg;
    logic [63:0] pb_reg;
    logic [31:0] word;

    assign word          = c_reg[pos_reg[1:0]];
    assign sts.buf_empty = pos_reg[2];
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign uniform_value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg    <= '0;
            key_hi_reg    <= '0;
            draw_cnt_reg  <= '0;
            hist_reg      <= HISTORY_RESET;
            pos_reg       <= POS_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_LO: key_lo_reg <= cfg_data;
                    CFG_KEY_HI: key_hi_reg <= cfg_data;
                    default:    key_lo_reg <= key_lo_reg;
                endcase
            end
            if (cmd.set_hist)
            begin
                hist_reg     <= history;
                draw_cnt_reg <= '0;
                pos_reg      <= POS_EMPTY;
            end
            else if (cmd.bump)
            begin
                draw_cnt_reg <= draw_cnt_reg + 64'd1;
                pos_reg      <= '0;
            end
            else if (cmd.emit)
            begin
                pos_reg <= pos_reg + 3'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg[0] <= draw_cnt_reg[31:0];
            c_reg[1] <= draw_cnt_reg[63:32];
            c_reg[2] <= hist_reg[31:0];
            c_reg[3] <= hist_reg[63:32];
            k0_reg   <= key_lo_reg;
            k1_reg   <= key_hi_reg;
        end
        else if (cmd.mix)
        begin
            c_reg[0] <= pb_reg[63:32] ^ c_reg[1] ^ k0_reg;
            c_reg[1] <= pb_reg[31:0];
            c_reg[2] <= pa_reg[63:32] ^ c_reg[3] ^ k1_reg;
            c_reg[3] <= pa_reg[31:0];
            k0_reg   <= k0_reg + WEYL_A;
            k1_reg   <= k1_reg + WEYL_B;
        end
        if (cmd.mul)
        begin
            pa_reg <= 64'(MUL_A) * 64'(c_reg[0]);
            pb_reg <= 64'(MUL_B) * 64'(c_reg[2]);
        end
        if (cmd.emit)
        begin
            out_value_reg <= {word, 1'b1};
        end
    end

endmodule

// ----- rtl/philox_uniform_stream_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// philox_uniform_stream_generator_top
// philox4x32 counter-based uniform generator with a four-word draw buffer
// ----------------------------------------------------------------------------
// A draw beat returns (2*w+1)/2^33 for the next buffered word w; a
// set-history beat loads the stream index, clears the draw counter and
// empties the buffer, and returns nothing. One item is in work at a time.
// A draw from a filled buffer is emitted straight from the idle state when the
// output register is free. A draw that finds the buffer empty first runs
// ROUNDS rounds on the single shared round unit, each a multiply step with
// two 32x32 multiplies followed by a mix step.
// The result sits in an output register, so a waiting result does not stall
// a set-history beat or a buffered draw until the register must be reused.
// ----------------------------------------------------------------------------
module philox_uniform_stream_generator_top
    import phx_pkg::*;
#(
    parameter int ROUNDS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [63:0] history,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [32:0] uniform_value
);

    phx_cmd_t cmd;
    phx_sts_t sts;

    phx_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    phx_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .history       (history),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .uniform_value (uniform_value)
    );

endmodule

// ----- rtl/phx_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_checker
// port-level checks of the philox uniform stream generator
// ----------------------------------------------------------------------------
module phx_checker
    import phx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [32:0] uniform_value
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(uniform_value))
        else $error("result beat changed while stalled");

    // every result is an odd fraction
    a_out_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> uniform_value[0])
        else $error("result beat is even");

    // set-history beat yields no result
    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_SET_HISTORY) && !out_valid |=> !out_valid)
        else $error("set-history beat produced a result");

    // a result rises only from a draw taken that cycle or a draw in work
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(!in_ready || (in_valid && op == OP_DRAW)))
        else $error("result appeared without a draw in work");

endmodule

bind philox_uniform_stream_generator_top phx_checker u_phx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .uniform_value (uniform_value)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the philox uniform stream generator against a software predictor
// ----------------------------------------------------------------------------
// Every accepted input beat is fed to a scoreboard. The scoreboard keeps its
// own copy of the key, the 128-bit counter and the four-word buffer, runs the
// philox rounds on a refill and queues the expected 33-bit fraction. Result
// beats are checked in order against that queue. Stimulus is a short
// directed part followed by random stream selects with draw bursts, under
// several keys. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import phx_pkg::*;

    localparam int ROUNDS        = 10;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 255;

    class uniform_scoreboard;
        bit [31:0] key_lo;
        bit [31:0] key_hi;
        bit [63:0] draw_count;
        bit [63:0] stream_index;
        bit [31:0] words [4];
        bit [2:0]  word_pos;
        bit [32:0] expected_values [$];
        int        errors;
        int        checked;
        int        refills;

        function new();
            key_lo       = '0;
            key_hi       = '0;
            draw_count   = '0;
            stream_index = HISTORY_RESET;
            word_pos     = POS_EMPTY;
            errors       = 0;
            checked      = 0;
            refills      = 0;
        endfunction

        function void set_key(logic idx, bit [31:0] data);
            if (idx == CFG_KEY_LO)
                key_lo = data;
            else
                key_hi = data;
        endfunction

        function void refill();
            bit [31:0] c0;
            bit [31:0] c1;
            bit [31:0] c2;
            bit [31:0] c3;
            bit [31:0] k0;
            bit [31:0] k1;
            bit [63:0] pa;
            bit [63:0] pb;
            c0 = draw_count[31:0];
            c1 = draw_count[63:32];
            c2 = stream_index[31:0];
            c3 = stream_index[63:32];
            k0 = key_lo;
            k1 = key_hi;
            for (int r = 0; r < ROUNDS; r++)
            begin
                pa = {32'b0, MUL_A} * {32'b0, c0};
                pb = {32'b0, MUL_B} * {32'b0, c2};
                c0 = pb[63:32] ^ c1 ^ k0;
                c1 = pb[31:0];
                c2 = pa[63:32] ^ c3 ^ k1;
                c3 = pa[31:0];
                k0 = k0 + WEYL_A;
                k1 = k1 + WEYL_B;
            end
            words[0]   = c0;
            words[1]   = c1;
            words[2]   = c2;
            words[3]   = c3;
            draw_count = draw_count + 64'd1;
            word_pos   = '0;
            refills++;
        endfunction

        function void note_beat(logic opcode, bit [63:0] hist);
            if (opcode == OP_SET_HISTORY)
            begin
                stream_index = hist;
                draw_count   = '0;
                word_pos     = POS_EMPTY;
            end
            else
            begin
                if (word_pos >= POS_EMPTY)
                    refill();
                expected_values.push_back({words[word_pos[1:0]], 1'b1});
                word_pos = word_pos + 3'd1;
            end
        endfunction

        function void check_value(logic [32:0] got);
            bit [32:0] want;
            if (expected_values.size() == 0)
            begin
                errors++;
                $display("%0t: uniform_value %h with no draw outstanding, expected none",
                         $time, got);
                return;
            end
            want = expected_values.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0t: uniform_value mismatch, expected %h, got %h",
                         $time, want, got);
            end
        endfunction

        function int outstanding();
            return expected_values.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [63:0] history;
    logic        out_valid;
    logic        out_ready;
    logic [32:0] uniform_value;

    uniform_scoreboard sb;
    int  cycle_count = 0;
    int  n_sets = 0;
    int  n_draws = 0;
    int  n_keys = 1;
    bit  send_idle;
    bit  recv_idle;

    philox_uniform_stream_generator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .history       (history),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .uniform_value (uniform_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d draws outstanding",
                 cycle_count, sb.outstanding());
        $display("Regression FAIL");
        $finish;
    end

    // results checked before the beat of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_value(uniform_value);
            if (in_valid && in_ready)
                sb.note_beat(op, history);
        end
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = recv_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    function automatic logic [63:0] rand_history();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return {32'hFFFF_FFFF, $urandom()};
            3: return {32'b0, $urandom_range(0, 255)};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_beat(logic opcode, logic [63:0] hist);
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= opcode;
        history  <= hist;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (opcode == OP_SET_HISTORY)
            n_sets++;
        else
            n_draws++;
    endtask

    task automatic draw_burst(int count);
        repeat (count) send_beat(OP_DRAW, {$urandom(), $urandom()});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_key(logic idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_key(idx, data);
        @(negedge clk);
    endtask

    task automatic run_streams(int n_items);
        int done;
        int burst;
        int pick;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                burst = $urandom_range(1, 12);
                send_beat(OP_SET_HISTORY, rand_history());
                draw_burst(burst);
                done += burst + 1;
            end
            else if (pick == 8)
            begin
                send_beat(OP_SET_HISTORY, rand_history());
                done++;
            end
            else
            begin
                // long run on one stream walks the draw counter further
                burst = $urandom_range(1, 60);
                draw_burst(burst);
                done += burst;
            end
        end
    endtask

    initial
    begin
        logic [31:0] keys_lo [6];
        logic [31:0] keys_hi [6];

        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_KEY_LO;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = OP_SET_HISTORY;
        history   = '0;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset stream and zero key, across two refills
        draw_burst(6);
        drain();
        write_key(CFG_KEY_LO, 32'hFFFF_FFFF);
        write_key(CFG_KEY_HI, 32'hFFFF_FFFF);
        n_keys++;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        // words buffered under the old key are still returned
        draw_burst(2);
        send_beat(OP_SET_HISTORY, 64'h0);
        draw_burst(5);
        send_beat(OP_SET_HISTORY, 64'hFFFF_FFFF_FFFF_FFFF);
        draw_burst(1);
        send_beat(OP_SET_HISTORY, 64'hAAAA_AAAA_AAAA_AAAA);
        draw_burst(1);
        send_beat(OP_SET_HISTORY, 64'h5555_5555_5555_5555);
        draw_burst(1);
        send_beat(OP_SET_HISTORY, 64'h0000_0001_0000_0000);
        send_beat(OP_SET_HISTORY, 64'h8000_0000_0000_0001);
        draw_burst(4);

        keys_lo = '{32'h0, 32'hFFFF_FFFF, $urandom(), $urandom(), 32'h0, $urandom()};
        keys_hi = '{32'hFFFF_FFFF, 32'h0, $urandom(), $urandom(), 32'h0, $urandom()};
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_key(CFG_KEY_LO, keys_lo[p]);
            write_key(CFG_KEY_HI, keys_hi[p]);
            n_keys++;
            case (p)
                0: begin send_idle = 1'b0; recv_idle = 1'b0; end
                1: begin send_idle = 1'b1; recv_idle = 1'b1; end
                2: begin send_idle = 1'b0; recv_idle = 1'b1; end
                3: begin send_idle = 1'b1; recv_idle = 1'b0; end
                default: begin send_idle = $urandom_range(0, 1); recv_idle = 1'b1; end
            endcase
            if (p == 2)
            begin
                run_streams(PHASE_ITEMS / 2);
                // hold off until the output side is empty
                in_valid <= 1'b0;
                while (sb.outstanding() != 0)
                    @(negedge clk);
                @(negedge clk);
                run_streams(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                run_streams(PHASE_ITEMS);
        end
        drain();

        $display("covered %0d input beats: %0d stream selects, %0d draws, %0d results checked",
                 n_sets + n_draws, n_sets, n_draws, sb.checked);
        $display("%0d buffer refills under %0d key settings, with and without stalls",
                 sb.refills, n_keys);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/phx_pkg.sv
rtl/phx_ctrl.sv
rtl/phx_datapath.sv
rtl/philox_uniform_stream_generator_top.sv
rtl/phx_checker.sv
dv/tb.sv
